// ===== rtl/core/process_group_refcount_tracker_macros.svh =====
// Assertion macros shared by the process group tracker RTL.
`ifndef PROCESS_GROUP_REFCOUNT_TRACKER_MACROS_SVH
`define PROCESS_GROUP_REFCOUNT_TRACKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PRGT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition leads to a result in the next cycle.
`define PRGT_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (res)) else $error(msg);

`endif

// ===== rtl/core/prgt_pkg.sv =====
// Shared constants, codes and types of the process group tracker.
package prgt_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PID_W    = 22;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned THREAD_W = 16;
  localparam int unsigned MEMBER_W = 7;

  localparam int unsigned PID_SLOTS_DEF   = 64;
  localparam int unsigned GROUP_SLOTS_DEF = 8;

  localparam logic [THREAD_W-1:0] THREAD_MAX = 16'hFFFF;
  localparam logic [MEMBER_W-1:0] MEMBER_MAX = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRACK = 2'd0,
    CMD_FORK  = 2'd1,
    CMD_EXIT  = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_IGNORED        = 4'd0,
    STATUS_TRACKED        = 4'd1,
    STATUS_DUPLICATE      = 4'd2,
    STATUS_THREAD_ADDED   = 4'd3,
    STATUS_FORKED         = 4'd4,
    STATUS_THREAD_EXITED  = 4'd5,
    STATUS_PROCESS_EXITED = 4'd6,
    STATUS_GROUP_ENDED    = 4'd7,
    STATUS_FULL           = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_GRD,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic                valid;
    logic [PID_W-1:0]    root;
    logic [MEMBER_W-1:0] members;
  } group_t;

endpackage

// ===== rtl/core/prgt_if.sv =====
// Event and result channel interfaces of the process group tracker.
interface prgt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [prgt_pkg::CMD_W-1:0]   command;
  logic [prgt_pkg::PID_W-1:0]   pid;
  logic [prgt_pkg::PID_W-1:0]   parent_pid;

  modport source (output valid, command, pid, parent_pid, input ready);
  modport sink   (input valid, command, pid, parent_pid, output ready);
endinterface

interface prgt_res_if;
  logic                          valid;
  logic                          ready;
  logic [prgt_pkg::STATUS_W-1:0] status;
  logic [prgt_pkg::SLOT_W-1:0]   group_slot;
  logic [prgt_pkg::PID_W-1:0]    event_pid;
  logic [prgt_pkg::PID_W-1:0]    related_pid;

  modport source (output valid, status, group_slot, event_pid, related_pid, input ready);
  modport sink   (input valid, status, group_slot, event_pid, related_pid, output ready);
endinterface

// ===== rtl/core/process_group_refcount_tracker.sv =====
// Top level of the process group tracker: scan, decide and update over two table RAMs.
//
//  channel | dir | beat contents                         | handshake
//  --------+-----+---------------------------------------+-------------
//  cmd     | in  | command, pid, parent_pid              | valid/ready
//  res     | out | status, group_slot, event_pid,        | valid/ready
//          |     | related_pid                           |
//
// An event runs from beat to beat through the idle state that takes the beat, a full
// read sweep of both table RAMs over max(PID_SLOTS, GROUP_SLOTS) indexes, the last
// read, one group RAM read and one decide/write-back step. After reset a clearing pass
// over max(PID_SLOTS, GROUP_SLOTS) indexes zeroes both RAMs with cmd.ready low. A result
// waits in the output register while the next event is taken; the decide cycle holds
// until that register is free.
`include "process_group_refcount_tracker_macros.svh"

module process_group_refcount_tracker #(
  parameter int unsigned PID_SLOTS   = prgt_pkg::PID_SLOTS_DEF,
  parameter int unsigned GROUP_SLOTS = prgt_pkg::GROUP_SLOTS_DEF
) (
  input logic             clk,
  input logic             rst,
  prgt_cmd_if.sink        cmd,
  prgt_res_if.source      res
);

  // Sweep covers both tables; each RAM only sees the indexes it holds.
  localparam int unsigned SCAN_LEN = (PID_SLOTS > GROUP_SLOTS) ? PID_SLOTS : GROUP_SLOTS;
  localparam int unsigned SW       = $clog2(SCAN_LEN);
  localparam int unsigned EW       = $clog2(PID_SLOTS);
  localparam int unsigned GW       = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;

  typedef struct packed {
    logic                          valid;
    logic [prgt_pkg::PID_W-1:0]    pid;
    logic [GW-1:0]                 grp;
    logic [prgt_pkg::THREAD_W-1:0] threads;
  } entry_t;

  prgt_pkg::state_t state, state_next;

  logic [SW-1:0] cnt;
  logic          cnt_last;
  logic          cnt_ent_ok, cnt_grp_ok;

  // Read pipeline of the sweep
  logic          rd_pend;
  logic [SW-1:0] rd_idx;
  logic          rd_ent_ok, rd_grp_ok;

  // Event being worked on
  prgt_pkg::command_t         cmd_r;
  logic [prgt_pkg::PID_W-1:0] pid_r, ppid_r;

  // What the sweep found
  logic                          child_hit;
  logic [EW-1:0]                 child_idx;
  logic [GW-1:0]                 child_grp;
  logic [prgt_pkg::THREAD_W-1:0] child_thr;
  logic                          par_hit;
  logic [GW-1:0]                 par_grp;
  logic                          fe_hit;
  logic [EW-1:0]                 fe_idx;
  logic                          fg_hit;
  logic [GW-1:0]                 fg_idx;

  // RAM ports
  logic             ent_we, grp_we;
  logic [EW-1:0]    ent_waddr, ent_raddr;
  logic [GW-1:0]    grp_waddr, grp_raddr;
  entry_t           ent_wdata, ent_rdata;
  prgt_pkg::group_t grp_wdata, grp_rdata;

  // Decision
  prgt_pkg::status_t          d_status;
  logic [GW-1:0]              d_slot;
  logic [prgt_pkg::PID_W-1:0] d_rel;
  logic                       d_ent_we, d_grp_we;
  logic [EW-1:0]              d_ent_addr;
  entry_t                     d_ent;
  logic [GW-1:0]              d_grp_addr;
  prgt_pkg::group_t           d_grp;
  logic [GW-1:0]              tgt_grp;
  logic [prgt_pkg::MEMBER_W-1:0] members_dec;

  // Output register
  logic                          res_valid;
  logic [prgt_pkg::STATUS_W-1:0] res_status;
  logic [prgt_pkg::SLOT_W-1:0]   res_slot;
  logic [prgt_pkg::PID_W-1:0]    res_pid, res_rel;
  logic                          out_free;
  logic                          load_res;

  // Assertion helpers
  logic in_sweep, cmd_beat, sweep_start, in_clear, plain_res;

  prgt_ram #(.WIDTH($bits(entry_t)), .DEPTH(PID_SLOTS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  prgt_ram #(.WIDTH($bits(prgt_pkg::group_t)), .DEPTH(GROUP_SLOTS)) u_group_ram (
    .clk   (clk),
    .we    (grp_we),
    .waddr (grp_waddr),
    .wdata (grp_wdata),
    .raddr (grp_raddr),
    .rdata (grp_rdata)
  );

  assign cnt_last   = (cnt == SW'(SCAN_LEN - 1));
  assign cnt_ent_ok = ({1'b0, cnt} < (SW + 1)'(PID_SLOTS));
  assign cnt_grp_ok = ({1'b0, cnt} < (SW + 1)'(GROUP_SLOTS));
  assign rd_ent_ok  = ({1'b0, rd_idx} < (SW + 1)'(PID_SLOTS));
  assign rd_grp_ok  = ({1'b0, rd_idx} < (SW + 1)'(GROUP_SLOTS));

  // A fork of an unknown child touches the parent's group; exits touch their own.
  assign tgt_grp  = (cmd_r == prgt_pkg::CMD_FORK) ? par_grp : child_grp;
  assign out_free = !res_valid || res.ready;

  assign cmd.ready       = (state == prgt_pkg::ST_IDLE);
  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.group_slot  = res_slot;
  assign res.event_pid   = res_pid;
  assign res.related_pid = res_rel;

  // Decide the outcome from the sweep results and the group entry just read.
  always_comb begin
    d_status    = prgt_pkg::STATUS_IGNORED;
    d_slot      = '0;
    d_rel       = '0;
    d_ent_we    = 1'b0;
    d_ent_addr  = fe_idx;
    d_ent       = '0;
    d_grp_we    = 1'b0;
    d_grp_addr  = tgt_grp;
    d_grp       = '0;
    members_dec = (grp_rdata.members != '0) ? grp_rdata.members - 1'b1 : '0;
    unique case (cmd_r)
      prgt_pkg::CMD_TRACK: begin
        if (child_hit) begin
          d_status = prgt_pkg::STATUS_DUPLICATE;
          d_slot   = child_grp;
        end else if (!fe_hit || !fg_hit) begin
          d_status = prgt_pkg::STATUS_FULL;
        end else begin
          d_ent_we   = 1'b1;
          d_ent      = '{valid: 1'b1, pid: pid_r, grp: fg_idx,
                         threads: prgt_pkg::THREAD_W'(1)};
          d_grp_we   = 1'b1;
          d_grp_addr = fg_idx;
          d_grp      = '{valid: 1'b1, root: pid_r, members: prgt_pkg::MEMBER_W'(1)};
          d_status   = prgt_pkg::STATUS_TRACKED;
          d_slot     = fg_idx;
        end
      end
      prgt_pkg::CMD_FORK: begin
        if (child_hit) begin
          // Known child: one more thread, saturating
          d_ent_we   = 1'b1;
          d_ent_addr = child_idx;
          d_ent      = '{valid: 1'b1, pid: pid_r, grp: child_grp,
                         threads: (child_thr == prgt_pkg::THREAD_MAX) ? child_thr
                                                                     : child_thr + 1'b1};
          d_status   = prgt_pkg::STATUS_THREAD_ADDED;
          d_slot     = child_grp;
        end else if (par_hit) begin
          d_slot = par_grp;
          if (!fe_hit || grp_rdata.members >= prgt_pkg::MEMBER_MAX) begin
            d_status = prgt_pkg::STATUS_FULL;
          end else begin
            d_ent_we = 1'b1;
            d_ent    = '{valid: 1'b1, pid: pid_r, grp: par_grp,
                         threads: prgt_pkg::THREAD_W'(1)};
            d_grp_we = 1'b1;
            d_grp    = '{valid: grp_rdata.valid, root: grp_rdata.root,
                         members: grp_rdata.members + 1'b1};
            d_status = prgt_pkg::STATUS_FORKED;
            d_rel    = ppid_r;
          end
        end
      end
      prgt_pkg::CMD_EXIT: begin
        if (child_hit) begin
          d_slot     = child_grp;
          d_ent_we   = 1'b1;
          d_ent_addr = child_idx;
          if (child_thr > prgt_pkg::THREAD_W'(1)) begin
            d_ent    = '{valid: 1'b1, pid: pid_r, grp: child_grp,
                         threads: child_thr - 1'b1};
            d_status = prgt_pkg::STATUS_THREAD_EXITED;
          end else begin
            // Last thread: free the entry and drop one member
            d_ent    = '0;
            d_grp_we = 1'b1;
            if (members_dec == '0) begin
              d_grp    = '{valid: 1'b0, root: grp_rdata.root, members: '0};
              d_status = prgt_pkg::STATUS_GROUP_ENDED;
              d_rel    = grp_rdata.root;
            end else begin
              d_grp    = '{valid: 1'b1, root: grp_rdata.root, members: members_dec};
              d_status = prgt_pkg::STATUS_PROCESS_EXITED;
            end
          end
        end
      end
      default: begin
        d_status = prgt_pkg::STATUS_IGNORED;
      end
    endcase
  end

  // Sequencer: next state and RAM port control.
  always_comb begin
    state_next = state;
    ent_we     = 1'b0;
    grp_we     = 1'b0;
    ent_waddr  = cnt[EW-1:0];
    ent_wdata  = '0;
    grp_waddr  = cnt[GW-1:0];
    grp_wdata  = '0;
    ent_raddr  = cnt[EW-1:0];
    grp_raddr  = cnt[GW-1:0];
    load_res   = 1'b0;
    unique case (state)
      prgt_pkg::ST_CLEAR: begin
        ent_we = cnt_ent_ok;
        grp_we = cnt_grp_ok;
        if (cnt_last) begin
          state_next = prgt_pkg::ST_IDLE;
        end
      end
      prgt_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = prgt_pkg::ST_SCAN;
        end
      end
      prgt_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_next = prgt_pkg::ST_TAIL;
        end
      end
      prgt_pkg::ST_TAIL: begin
        state_next = prgt_pkg::ST_GRD;
      end
      prgt_pkg::ST_GRD: begin
        grp_raddr  = tgt_grp;
        state_next = prgt_pkg::ST_DECIDE;
      end
      prgt_pkg::ST_DECIDE: begin
        // Hold the group read address so the data stays put while stalled
        grp_raddr = tgt_grp;
        ent_waddr = d_ent_addr;
        ent_wdata = d_ent;
        grp_waddr = d_grp_addr;
        grp_wdata = d_grp;
        if (out_free) begin
          ent_we     = d_ent_we;
          grp_we     = d_grp_we;
          load_res   = 1'b1;
          state_next = prgt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prgt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prgt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter, read pipeline and match capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_pend   <= 1'b0;
      child_hit <= 1'b0;
      par_hit   <= 1'b0;
      fe_hit    <= 1'b0;
      fg_hit    <= 1'b0;
    end else begin
      rd_pend <= (state == prgt_pkg::ST_SCAN);
      rd_idx  <= cnt;
      if (state == prgt_pkg::ST_CLEAR || state == prgt_pkg::ST_SCAN) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (state == prgt_pkg::ST_IDLE && cmd.valid) begin
        cmd_r     <= prgt_pkg::command_t'(cmd.command);
        pid_r     <= cmd.pid;
        ppid_r    <= cmd.parent_pid;
        cnt       <= '0;
        child_hit <= 1'b0;
        par_hit   <= 1'b0;
        fe_hit    <= 1'b0;
        fg_hit    <= 1'b0;
      end else if (rd_pend) begin
        // Keep the first match; free slots go lowest first
        if (rd_ent_ok && ent_rdata.valid && ent_rdata.pid == pid_r && !child_hit) begin
          child_hit <= 1'b1;
          child_idx <= rd_idx[EW-1:0];
          child_grp <= ent_rdata.grp;
          child_thr <= ent_rdata.threads;
        end
        if (rd_ent_ok && ent_rdata.valid && ent_rdata.pid == ppid_r && !par_hit) begin
          par_hit <= 1'b1;
          par_grp <= ent_rdata.grp;
        end
        if (rd_ent_ok && !ent_rdata.valid && !fe_hit) begin
          fe_hit <= 1'b1;
          fe_idx <= rd_idx[EW-1:0];
        end
        if (rd_grp_ok && !grp_rdata.valid && !fg_hit) begin
          fg_hit <= 1'b1;
          fg_idx <= rd_idx[GW-1:0];
        end
      end
    end
  end

  // Output register: load on decide, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status <= d_status;
      res_slot   <= prgt_pkg::SLOT_W'(d_slot);
      res_pid    <= pid_r;
      res_rel    <= d_rel;
    end
  end

  assign in_sweep    = (state == prgt_pkg::ST_SCAN) || (state == prgt_pkg::ST_TAIL) ||
                       (state == prgt_pkg::ST_GRD);
  assign cmd_beat    = cmd.valid && cmd.ready;
  assign sweep_start = (state == prgt_pkg::ST_SCAN) && (cnt == '0);
  assign in_clear    = (state == prgt_pkg::ST_CLEAR);
  assign plain_res   = res.valid && (res.status != prgt_pkg::STATUS_FORKED) &&
                       (res.status != prgt_pkg::STATUS_GROUP_ENDED);

  `PRGT_ASSERT(a_no_write_in_sweep, in_sweep |-> !(ent_we || grp_we), "table write during sweep")
  `PRGT_ASSERT_NEXT(a_beat_starts_sweep, cmd_beat, sweep_start, "beat did not start a sweep")
  `PRGT_ASSERT(a_clear_after_reset, $past(rst) |-> in_clear, "clearing pass skipped after reset")
  `PRGT_ASSERT(a_related_zero, plain_res |-> res.related_pid == '0, "stray related pid")

endmodule

// ===== rtl/core/prgt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module prgt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
